>>> hdl/ses_pkg.sv
// Shared types, widths and constants for the shell energy spectrum unit.
// Used by every file in hdl/; depends on nothing.
package ses_pkg;

    // Grid size along the first index (row wraps negative above N1/2).
    localparam int N1           = 64;
    localparam int NUM_BINS_DEF = 64;

    localparam int IDX_W      = 6;
    localparam int COMP_W     = 16;
    localparam int NUM_COMP   = 6;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int SQ_W       = 12;   // square of a 6-bit index
    localparam int K2_W       = 46;   // three Q16.16 scale * index square terms
    localparam int ENERGY_W   = 33;   // six Q2.30 squares
    localparam int SUM_W      = 48;   // stored shell sum
    localparam int BIN_PORT_W = 6;
    localparam int MUL_W      = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 32'h0001_0000;

    localparam logic [CFG_IDX_W-1:0] REG_WAVENUM1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAVENUM2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVENUM3 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_WRITE,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic [IDX_W-1:0]                 row;
        logic [IDX_W-1:0]                 col;
        logic [IDX_W-1:0]                 depth;
        logic [NUM_COMP-1:0][COMP_W-1:0]  comp;  // x_re, x_im, y_re, y_im, z_re, z_im
    } element_t;

    typedef struct packed {
        logic [CFG_W-1:0] wavenum1_sq;
        logic [CFG_W-1:0] wavenum2_sq;
        logic [CFG_W-1:0] wavenum3_sq;
        logic [CFG_W-1:0] inv_step;
    } scale_t;

    typedef struct packed {
        logic                  done;
        logic [BIN_PORT_W-1:0] bin;
        logic [ENERGY_W-1:0]   energy;
    } calc_status_t;

endpackage

>>> hdl/shell_energy_spectrum_unit.sv
// Top level of the shell energy spectrum unit: control, config and shell store.
// Depends on ses_pkg, ses_bin_calc and ses_ram.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------
//  item in   | start & !busy             | kind, row/col/depth_index, x/y/z re/im
//  result    | result_strobe (1 cycle)   | bin_number, shell_energy, last_bin
//  config    | cfg_write_enable          | cfg_index, cfg_data
//
// An accumulate transaction holds busy while the shared multiplier steps through
// 14 products (index squares, scaled k2 terms, six component squares, two bin
// products), then the store is read and written back, one access each; the next
// item is taken only once busy drops. A flush transaction makes one store read
// per bin, each result strobed the cycle after its read, bins in ascending order.
// Reset clears the config registers to 1.0 and every shell to zero at once
// through per-bin valid bits; there is no clearing pass. The receiver cannot
// stall: results are shown for exactly one cycle.
module shell_energy_spectrum_unit #(
    parameter int NUM_BINS = ses_pkg::NUM_BINS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              kind,
    input  logic [ses_pkg::IDX_W-1:0]         row_index,
    input  logic [ses_pkg::IDX_W-1:0]         col_index,
    input  logic [ses_pkg::IDX_W-1:0]         depth_index,
    input  logic signed [ses_pkg::COMP_W-1:0] x_real,
    input  logic signed [ses_pkg::COMP_W-1:0] x_imag,
    input  logic signed [ses_pkg::COMP_W-1:0] y_real,
    input  logic signed [ses_pkg::COMP_W-1:0] y_imag,
    input  logic signed [ses_pkg::COMP_W-1:0] z_real,
    input  logic signed [ses_pkg::COMP_W-1:0] z_imag,
    output logic                              result_strobe,
    output logic [ses_pkg::BIN_PORT_W-1:0]    bin_number,
    output logic [ses_pkg::SUM_W-1:0]         shell_energy,
    output logic                              last_bin,
    input  logic                              cfg_write_enable,
    input  logic [ses_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ses_pkg::CFG_W-1:0]         cfg_data
);

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [BIN_W-1:0] LAST_ADDR = BIN_W'(NUM_BINS - 1);
    localparam int SUM_W = ses_pkg::SUM_W;

    ses_pkg::ctrl_state_t   state_reg, state_next;
    ses_pkg::scale_t        scales_reg;
    ses_pkg::element_t      element;
    ses_pkg::calc_status_t  status;

    logic                   go;
    logic [NUM_BINS-1:0]    valid_reg, valid_next;
    logic [BIN_W-1:0]       flush_cnt_reg, flush_cnt_next;
    logic                   strobe_reg, strobe_next;
    logic                   last_reg, last_next;
    logic [BIN_W-1:0]       out_bin_reg, out_bin_next;
    logic                   rd_valid_reg, rd_valid_next;

    logic                   ram_we, ram_re;
    logic [BIN_W-1:0]       ram_addr;
    logic [SUM_W-1:0]       ram_wdata, ram_rdata;
    logic [SUM_W-1:0]       old_sum;
    logic [SUM_W:0]         sum_wide;

    // Config registers: written any time the enable is high, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scales_reg.wavenum1_sq <= ses_pkg::CFG_RESET;
            scales_reg.wavenum2_sq <= ses_pkg::CFG_RESET;
            scales_reg.wavenum3_sq <= ses_pkg::CFG_RESET;
            scales_reg.inv_step    <= ses_pkg::CFG_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                ses_pkg::REG_WAVENUM1: scales_reg.wavenum1_sq <= cfg_data;
                ses_pkg::REG_WAVENUM2: scales_reg.wavenum2_sq <= cfg_data;
                ses_pkg::REG_WAVENUM3: scales_reg.wavenum3_sq <= cfg_data;
                ses_pkg::REG_INV_STEP: scales_reg.inv_step    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign element.row   = row_index;
    assign element.col   = col_index;
    assign element.depth = depth_index;
    assign element.comp  = {x_real, x_imag, y_real, y_imag, z_real, z_imag};

    assign busy = (state_reg != ses_pkg::ST_IDLE);
    assign go   = start && !busy && !kind;

    ses_bin_calc #(
        .NUM_BINS (NUM_BINS)
    ) u_bin_calc (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .element (element),
        .scales  (scales_reg),
        .status  (status)
    );

    // A shell that was never written since reset or flush reads as zero.
    assign old_sum   = rd_valid_reg ? ram_rdata : '0;
    assign sum_wide  = {1'b0, old_sum} + (SUM_W + 1)'(status.energy);
    assign ram_wdata = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        flush_cnt_next = flush_cnt_reg;
        strobe_next    = 1'b0;
        last_next      = 1'b0;
        out_bin_next   = out_bin_reg;
        rd_valid_next  = rd_valid_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = status.bin[BIN_W-1:0];
        unique case (state_reg)
            ses_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (kind)
                    begin
                        state_next     = ses_pkg::ST_FLUSH;
                        flush_cnt_next = '0;
                    end
                    else
                    begin
                        state_next = ses_pkg::ST_CALC;
                    end
                end
            end
            ses_pkg::ST_CALC:
            begin
                // Hold until the bin and energy are ready.
                if (status.done)
                begin
                    state_next = ses_pkg::ST_READ;
                end
            end
            ses_pkg::ST_READ:
            begin
                ram_re        = 1'b1;
                rd_valid_next = valid_reg[ram_addr];
                state_next    = ses_pkg::ST_WRITE;
            end
            ses_pkg::ST_WRITE:
            begin
                ram_we               = 1'b1;
                valid_next[ram_addr] = 1'b1;
                state_next           = ses_pkg::ST_IDLE;
            end
            ses_pkg::ST_FLUSH:
            begin
                // Read one shell, drop its valid bit, strobe it next cycle.
                ram_addr             = flush_cnt_reg;
                ram_re               = 1'b1;
                rd_valid_next        = valid_reg[ram_addr];
                valid_next[ram_addr] = 1'b0;
                strobe_next          = 1'b1;
                out_bin_next         = flush_cnt_reg;
                if (flush_cnt_reg == LAST_ADDR)
                begin
                    last_next  = 1'b1;
                    state_next = ses_pkg::ST_IDLE;
                end
                else
                begin
                    flush_cnt_next = flush_cnt_reg + BIN_W'(1);
                end
            end
            default:
            begin
                state_next = ses_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ses_pkg::ST_IDLE;
            valid_reg     <= '0;
            flush_cnt_reg <= '0;
            strobe_reg    <= 1'b0;
            last_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            flush_cnt_reg <= flush_cnt_next;
            strobe_reg    <= strobe_next;
            last_reg      <= last_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bin_reg <= out_bin_next;
    end

    ses_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NUM_BINS)
    ) u_shell_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign result_strobe = strobe_reg;
    assign bin_number    = ses_pkg::BIN_PORT_W'(out_bin_reg);
    assign shell_energy  = old_sum;
    assign last_bin      = last_reg;

`ifndef SYNTHESIS
    a_strobe_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == ses_pkg::ST_FLUSH))
        else $error("result strobe without a flush read");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store read and write in the same cycle");

    a_last_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_bin) |-> (state_reg == ses_pkg::ST_IDLE))
        else $error("flush still running after last bin");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> (state_reg == ses_pkg::ST_CALC))
        else $error("bin result arrived outside the calc state");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(ram_addr)])
        else $error("written shell not marked valid");
`endif

endmodule

>>> hdl/ses_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Depends on ses_pkg for default sizes.
module ses_ram #(
    parameter int WIDTH = ses_pkg::SUM_W,
    parameter int DEPTH = ses_pkg::NUM_BINS_DEF
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> hdl/ses_bin_calc.sv
// Shell bin and element energy sequencer around one shared 32x32 multiplier.
// Depends on ses_pkg (element_t, scale_t, calc_status_t, widths).
module ses_bin_calc #(
    parameter int NUM_BINS = ses_pkg::NUM_BINS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  ses_pkg::element_t       element,
    input  ses_pkg::scale_t         scales,
    output ses_pkg::calc_status_t   status
);

    localparam logic [3:0] STEP_SQ_A = 4'd0;
    localparam logic [3:0] STEP_SQ_C = 4'd1;
    localparam logic [3:0] STEP_SQ_D = 4'd2;
    localparam logic [3:0] STEP_K2_1 = 4'd3;
    localparam logic [3:0] STEP_K2_2 = 4'd4;
    localparam logic [3:0] STEP_K2_3 = 4'd5;
    localparam logic [3:0] STEP_E0   = 4'd6;
    localparam logic [3:0] STEP_E1   = 4'd7;
    localparam logic [3:0] STEP_E5   = 4'd11;
    localparam logic [3:0] STEP_LO   = 4'd12;
    localparam logic [3:0] STEP_BIN  = 4'd13;

    localparam logic [10:0] ROW_N    = 11'(ses_pkg::N1);
    localparam logic [10:0] ROW_HALF = 11'(ses_pkg::N1 / 2);
    localparam int          RAW_W    = ses_pkg::K2_W + 1;
    localparam logic [RAW_W-1:0] BIN_LAST = RAW_W'(NUM_BINS - 1);

    logic                                               run_reg, run_next;
    logic [3:0]                                         step_reg, step_next;
    logic                                               done_reg, done_next;

    logic [ses_pkg::IDX_W-1:0]                          a_reg, col_reg, depth_reg;
    logic [ses_pkg::NUM_COMP-1:0][ses_pkg::COMP_W-1:0]  comp_reg;
    logic [ses_pkg::SQ_W-1:0]                           sq_a_reg, sq_c_reg, sq_d_reg;
    logic [ses_pkg::SQ_W-1:0]                           sq_a_next, sq_c_next, sq_d_next;
    logic [ses_pkg::K2_W-1:0]                           k2_reg, k2_next;
    logic [ses_pkg::ENERGY_W-1:0]                       e_reg, e_next;
    logic [ses_pkg::MUL_W-1:0]                          t_reg, t_next;
    logic [ses_pkg::BIN_PORT_W-1:0]                     bin_reg, bin_next;

    logic [10:0]                                        row_ext, a_fold;
    logic [2:0]                                         comp_sel;
    logic [ses_pkg::COMP_W-1:0]                         comp_raw, comp_mag;
    logic [ses_pkg::MUL_W-1:0]                          mul_x, mul_y;
    logic [2*ses_pkg::MUL_W-1:0]                        prod;
    logic [RAW_W-1:0]                                   raw_bin;

    // Fold the row index to its distance from zero on the wrapped axis.
    assign row_ext = 11'(element.row);
    assign a_fold  = (row_ext > ROW_HALF)
                   ? ((row_ext > ROW_N) ? (row_ext - ROW_N) : (ROW_N - row_ext))
                   : row_ext;

    // Component magnitude: squaring |v| equals squaring v.
    assign comp_sel = 3'(step_reg - STEP_E0);
    assign comp_raw = comp_reg[comp_sel];
    assign comp_mag = comp_raw[ses_pkg::COMP_W-1] ? (~comp_raw + 16'd1) : comp_raw;

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (step_reg) inside
            STEP_SQ_A:
            begin
                mul_x = 32'(a_reg);
                mul_y = 32'(a_reg);
            end
            STEP_SQ_C:
            begin
                mul_x = 32'(col_reg);
                mul_y = 32'(col_reg);
            end
            STEP_SQ_D:
            begin
                mul_x = 32'(depth_reg);
                mul_y = 32'(depth_reg);
            end
            STEP_K2_1:
            begin
                mul_x = scales.wavenum1_sq;
                mul_y = 32'(sq_a_reg);
            end
            STEP_K2_2:
            begin
                mul_x = scales.wavenum2_sq;
                mul_y = 32'(sq_c_reg);
            end
            STEP_K2_3:
            begin
                mul_x = scales.wavenum3_sq;
                mul_y = 32'(sq_d_reg);
            end
            [STEP_E0:STEP_E5]:
            begin
                mul_x = 32'(comp_mag);
                mul_y = 32'(comp_mag);
            end
            STEP_LO:
            begin
                mul_x = scales.inv_step;
                mul_y = k2_reg[31:0];
            end
            STEP_BIN:
            begin
                mul_x = scales.inv_step;
                mul_y = 32'(k2_reg[ses_pkg::K2_W-1:32]);
            end
            default:
            begin
            end
        endcase
    end

    assign prod    = 64'(mul_x) * 64'(mul_y);
    assign raw_bin = RAW_W'(prod[ses_pkg::K2_W-1:0]) + RAW_W'(t_reg);

    // Datapath next values: each step writes or adds one product into its destination; the bin step clamps.
    always_comb
    begin
        sq_a_next = sq_a_reg;
        sq_c_next = sq_c_reg;
        sq_d_next = sq_d_reg;
        k2_next   = k2_reg;
        e_next    = e_reg;
        t_next    = t_reg;
        bin_next  = bin_reg;
        if (run_reg)
        begin
            unique case (step_reg) inside
                STEP_SQ_A: sq_a_next = prod[ses_pkg::SQ_W-1:0];
                STEP_SQ_C: sq_c_next = prod[ses_pkg::SQ_W-1:0];
                STEP_SQ_D: sq_d_next = prod[ses_pkg::SQ_W-1:0];
                STEP_K2_1: k2_next   = prod[ses_pkg::K2_W-1:0];
                [STEP_K2_2:STEP_K2_3]:
                    k2_next = k2_reg + prod[ses_pkg::K2_W-1:0];
                STEP_E0:   e_next    = prod[ses_pkg::ENERGY_W-1:0];
                [STEP_E1:STEP_E5]:
                    e_next = e_reg + prod[ses_pkg::ENERGY_W-1:0];
                STEP_LO:   t_next    = prod[63:32];
                STEP_BIN:
                    bin_next = (raw_bin > BIN_LAST)
                             ? ses_pkg::BIN_PORT_W'(NUM_BINS - 1)
                             : raw_bin[ses_pkg::BIN_PORT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: advance one step a cycle, drop out after the bin step.
    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (go)
        begin
            run_next  = 1'b1;
            step_next = STEP_SQ_A;
        end
        else if (run_reg)
        begin
            if (step_reg == STEP_BIN)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= STEP_SQ_A;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg     <= a_fold[ses_pkg::IDX_W-1:0];
            col_reg   <= element.col;
            depth_reg <= element.depth;
            comp_reg  <= element.comp;
        end
        sq_a_reg <= sq_a_next;
        sq_c_reg <= sq_c_next;
        sq_d_reg <= sq_d_next;
        k2_reg   <= k2_next;
        e_reg    <= e_next;
        t_reg    <= t_next;
        bin_reg  <= bin_next;
    end

    assign status.done   = done_reg;
    assign status.bin    = bin_reg;
    assign status.energy = e_reg;

endmodule
